// ===== src/psg_pkg.sv =====
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, register codes and the volume table of the sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

    localparam int NUM_CH = 3;

    // item kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // register numbers
    localparam logic [3:0] REG_TONE0_LO = 4'd0;
    localparam logic [3:0] REG_NOISE    = 4'd6;
    localparam logic [3:0] REG_MIXER    = 4'd7;
    localparam logic [3:0] REG_AMP0     = 4'd8;
    localparam logic [3:0] REG_ENV_LO   = 4'd11;
    localparam logic [3:0] REG_ENV_HI   = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    // bit 17 lands on the top bit of the 17-bit shifter after the shift
    localparam logic [17:0] LFSR_TAPS = 18'h24000;
    localparam logic [15:0] MIX_BIAS  = 16'h8000;
    localparam logic [7:0]  MIDSCALE  = 8'h80;

    // programmed periods, mixer and volumes
    typedef struct packed {
        logic [NUM_CH-1:0][11:0] tone_raw;
        logic [4:0]              noise_raw;
        logic [5:0]              mixer;
        logic [NUM_CH-1:0][4:0]  amp;
        logic [15:0]             env_raw;
    } t_psg_cfg;

    // envelope shape write
    typedef struct packed {
        logic       wr;
        logic [3:0] shape;
    } t_psg_shape;

    // generator levels after a tick
    typedef struct packed {
        logic [NUM_CH-1:0] tone;
        logic              noise;
        logic [3:0]        env_vol;
    } t_psg_lvl;

    function automatic logic [13:0] level_dac(input logic [3:0] idx);
        logic [13:0] lvl;
        unique case (idx)
            4'd0:    lvl = 14'd30;
            4'd1:    lvl = 14'd406;
            4'd2:    lvl = 14'd788;
            4'd3:    lvl = 14'd1177;
            4'd4:    lvl = 14'd1577;
            4'd5:    lvl = 14'd1991;
            4'd6:    lvl = 14'd2426;
            4'd7:    lvl = 14'd2890;
            4'd8:    lvl = 14'd3395;
            4'd9:    lvl = 14'd3959;
            4'd10:   lvl = 14'd4606;
            4'd11:   lvl = 14'd5370;
            4'd12:   lvl = 14'd6300;
            4'd13:   lvl = 14'd7463;
            4'd14:   lvl = 14'd8958;
            default: lvl = 14'd10922;
        endcase
        return lvl;
    endfunction

endpackage

// ===== src/psg_regs.sv =====
// ----------------------------------------------------------------------------
// psg_regs
// Register file: decodes writes into periods, mixer, volumes and shape.
// ----------------------------------------------------------------------------
module psg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [3:0]           i_addr,
    input  logic [7:0]           i_value,
    output psg_pkg::t_psg_cfg    o_cfg,
    output psg_pkg::t_psg_shape  o_shape
);
    import psg_pkg::*;

    t_psg_cfg r_cfg;
    t_psg_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (i_addr == REG_TONE0_LO + 4'(2 * c)) begin
                    n_cfg.tone_raw[c][7:0] = i_value;
                end
                if (i_addr == REG_TONE0_LO + 4'(2 * c + 1)) begin
                    n_cfg.tone_raw[c][11:8] = i_value[3:0];
                end
                if (i_addr == REG_AMP0 + 4'(c)) begin
                    n_cfg.amp[c] = i_value[4:0];
                end
            end
            if (i_addr == REG_NOISE) begin
                n_cfg.noise_raw = i_value[4:0];
            end
            if (i_addr == REG_MIXER) begin
                n_cfg.mixer = i_value[5:0];
            end
            if (i_addr == REG_ENV_LO) begin
                n_cfg.env_raw[7:0] = i_value;
            end
            if (i_addr == REG_ENV_HI) begin
                n_cfg.env_raw[15:8] = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg         = r_cfg;
    assign o_shape.wr    = i_wr && (i_addr == REG_ENV_SHAPE);
    assign o_shape.shape = i_value[3:0];

endmodule

// ===== src/psg_gen.sv =====
// ----------------------------------------------------------------------------
// psg_gen
// Tone dividers, noise divider with LFSR, envelope divider and sequencer.
// ----------------------------------------------------------------------------
module psg_gen (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  psg_pkg::t_psg_cfg    i_cfg,
    input  psg_pkg::t_psg_shape  i_shape,
    output psg_pkg::t_psg_lvl    o_lvl
);
    import psg_pkg::*;

    logic [NUM_CH-1:0][11:0] r_tone_cnt,  n_tone_cnt;
    logic [NUM_CH-1:0]       r_tone_lvl,  n_tone_lvl;
    logic [4:0]              r_noise_cnt, n_noise_cnt;
    logic [16:0]             r_noise_shift, n_noise_shift;
    logic                    r_noise_lvl, n_noise_lvl;
    logic [16:0]             r_env_cnt,   n_env_cnt;
    logic [3:0]              r_env_pos,   n_env_pos;
    logic                    r_env_attack, n_env_attack;
    logic                    r_env_alt,    n_env_alt;
    logic                    r_env_hold,   n_env_hold;
    logic                    r_env_holding, n_env_holding;

    logic [11:0] tone_per;
    logic [4:0]  noise_per;
    logic [16:0] env_per;

    always_comb begin
        n_tone_cnt    = r_tone_cnt;
        n_tone_lvl    = r_tone_lvl;
        n_noise_cnt   = r_noise_cnt;
        n_noise_shift = r_noise_shift;
        n_noise_lvl   = r_noise_lvl;
        n_env_cnt     = r_env_cnt;
        n_env_pos     = r_env_pos;
        n_env_attack  = r_env_attack;
        n_env_alt     = r_env_alt;
        n_env_hold    = r_env_hold;
        n_env_holding = r_env_holding;
        tone_per      = 12'd1;
        // zero periods act as the shortest period
        noise_per = (i_cfg.noise_raw == 5'd0) ? 5'd1 : i_cfg.noise_raw;
        env_per   = {((i_cfg.env_raw == 16'd0) ? 16'd1 : i_cfg.env_raw), 1'b0};

        if (i_shape.wr) begin
            n_env_pos     = 4'd15;
            n_env_holding = 1'b0;
            n_env_attack  = i_shape.shape[2];
            n_env_hold    = !i_shape.shape[3] || i_shape.shape[0];
            n_env_alt     = i_shape.shape[3] ? i_shape.shape[1] : i_shape.shape[2];
        end else if (i_tick) begin
            n_noise_cnt = r_noise_cnt + 5'd1;
            if (n_noise_cnt >= noise_per) begin
                n_noise_cnt   = 5'd0;
                n_noise_lvl   = r_noise_lvl ^ r_noise_shift[1] ^ r_noise_shift[0];
                n_noise_shift = r_noise_shift[0] ?
                    {LFSR_TAPS[17], r_noise_shift[16:1] ^ LFSR_TAPS[16:1]} :
                    {1'b0, r_noise_shift[16:1]};
            end

            if (!r_env_holding) begin
                n_env_cnt = r_env_cnt + 17'd1;
                if (n_env_cnt >= env_per) begin
                    n_env_cnt = 17'd0;
                    if (r_env_pos == 4'd0) begin
                        // end of a ramp: flip direction if alternating, then hold or restart
                        n_env_attack  = r_env_attack ^ r_env_alt;
                        n_env_pos     = r_env_hold ? 4'd0 : 4'd15;
                        n_env_holding = r_env_hold;
                    end else begin
                        n_env_pos = r_env_pos - 4'd1;
                    end
                end
            end

            for (int c = 0; c < NUM_CH; c++) begin
                tone_per = (i_cfg.tone_raw[c] == 12'd0) ? 12'd1 : i_cfg.tone_raw[c];
                n_tone_cnt[c] = r_tone_cnt[c] + 12'd1;
                if (n_tone_cnt[c] >= tone_per) begin
                    n_tone_cnt[c] = 12'd0;
                    n_tone_lvl[c] = !r_tone_lvl[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_cnt    <= '0;
            r_tone_lvl    <= '0;
            r_noise_cnt   <= 5'd0;
            r_noise_shift <= 17'd1;
            r_noise_lvl   <= 1'b1;
            r_env_cnt     <= 17'd0;
            r_env_pos     <= 4'd15;
            r_env_attack  <= 1'b0;
            r_env_alt     <= 1'b0;
            r_env_hold    <= 1'b1;
            r_env_holding <= 1'b0;
        end else begin
            r_tone_cnt    <= n_tone_cnt;
            r_tone_lvl    <= n_tone_lvl;
            r_noise_cnt   <= n_noise_cnt;
            r_noise_shift <= n_noise_shift;
            r_noise_lvl   <= n_noise_lvl;
            r_env_cnt     <= n_env_cnt;
            r_env_pos     <= n_env_pos;
            r_env_attack  <= n_env_attack;
            r_env_alt     <= n_env_alt;
            r_env_hold    <= n_env_hold;
            r_env_holding <= n_env_holding;
        end
    end

    // the mixer sees the levels as they stand after this tick
    assign o_lvl.tone    = n_tone_lvl;
    assign o_lvl.noise   = n_noise_lvl;
    assign o_lvl.env_vol = n_env_pos ^ {4{n_env_attack}};

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise_shift != 17'd0)
        else $error("noise lfsr reached the all-zero state");

    a_hold_at_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env_holding |-> (r_env_pos == 4'd0))
        else $error("envelope holding away from position zero");

endmodule

// ===== src/psg_mix.sv =====
// ----------------------------------------------------------------------------
// psg_mix
// Channel mixer, volume table lookup and output register.
// ----------------------------------------------------------------------------
module psg_mix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_sound_en,
    input  psg_pkg::t_psg_cfg  i_cfg,
    input  psg_pkg::t_psg_lvl  i_lvl,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [7:0]         o_out_sample
);
    import psg_pkg::*;

    logic        r_valid, n_valid;
    logic [7:0]  r_sample;
    logic [15:0] vol;
    logic [3:0]  idx;

    always_comb begin
        vol = MIX_BIAS;
        idx = 4'd0;
        for (int c = 0; c < NUM_CH; c++) begin
            idx = i_cfg.amp[c][4] ? i_lvl.env_vol : i_cfg.amp[c][3:0];
            if ((i_lvl.tone[c] || i_cfg.mixer[c]) && (i_lvl.noise || i_cfg.mixer[c + 3])) begin
                vol = vol + {2'b00, level_dac(idx)};
            end
        end
    end

    always_comb begin
        n_valid = r_valid && i_out_stall;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= i_sound_en ? vol[15:8] : MIDSCALE;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_sample = r_sample;

endmodule

// ===== src/psg_tone_noise_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope_generator
// Three-channel tone, noise and envelope sound generator.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries register writes
// (i_in_func = 0, i_in_reg_addr, i_in_reg_value) and sample ticks
// (i_in_func = 1). Each tick yields one 8-bit sample on the output channel
// (o_out_valid / i_out_stall); a write yields nothing.
// An accepted item waits in the input register and is processed
// as it leaves it: a write updates the register file, a tick advances the
// dividers and loads the sample register. A sample is valid from the edge
// at which its tick leaves the input register. One item per cycle is taken,
// sustained, while the receiver does not stall.
// When the receiver stalls, the held sample stays put and further writes
// still go through; a tick behind it waits in the input register until
// the sample register frees, and while it waits the input channel stalls.
// i_cfg_we / i_cfg_wdata set the sound enable bit (0 forces 128); write
// it only while the block is idle.
// Synchronous reset clears the registers to zero, the periods to their
// shortest values, the noise LFSR to one and enables sound; no item or
// sample is pending after reset.
// ----------------------------------------------------------------------------
module psg_tone_noise_envelope_generator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_in_func,
    input  logic [3:0] i_in_reg_addr,
    input  logic [7:0] i_in_reg_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_sample,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);
    import psg_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic       r_func;
    logic [3:0] r_addr;
    logic [7:0] r_value;
    logic       r_sound_en;

    logic       accept;
    logic       advance;
    logic       adv_write;
    logic       adv_tick;

    t_psg_cfg   cfg;
    t_psg_shape shape;
    t_psg_lvl   lvl;

    // a write never needs the sample register, a tick needs it free
    assign advance   = r_in_valid &&
                       ((r_func == FUNC_WRITE) || !o_out_valid || !i_out_stall);
    assign adv_write = advance && (r_func == FUNC_WRITE);
    assign adv_tick  = advance && (r_func == FUNC_TICK);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_sound_en <= 1'b1;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_sound_en <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_in_func;
            r_addr  <= i_in_reg_addr;
            r_value <= i_in_reg_value;
        end
    end

    psg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (adv_write),
        .i_addr  (r_addr),
        .i_value (r_value),
        .o_cfg   (cfg),
        .o_shape (shape)
    );

    psg_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (adv_tick),
        .i_cfg   (cfg),
        .i_shape (shape),
        .o_lvl   (lvl)
    );

    psg_mix u_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (adv_tick),
        .i_sound_en   (r_sound_en),
        .i_cfg        (cfg),
        .i_lvl        (lvl),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_sample (o_out_sample)
    );

    a_tick_gives_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_tick |=> o_out_valid)
        else $error("tick left the input register without a sample");

    a_write_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_func == FUNC_WRITE) && !o_out_valid) |=> !o_out_valid)
        else $error("register write produced a sample");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && (r_func == FUNC_TICK) && o_out_valid))
        else $error("input stalled without a blocked tick");

endmodule
